FILE: rtl/core/imkr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imkr_pkg
// Types and constants shared by the I2C key reader core: request kinds,
// queue entries, sequencer phases and the result word.
// ----------------------------------------------------------------------------
package imkr_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request codes on the req_type port.
  localparam logic [1:0] REQ_KEY_IRQ = 2'd1;
  localparam logic [1:0] REQ_HOST_RD = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_TICKS_US    = 2'd2;

  localparam logic [7:0]  DEV_ADDR_RESET    = 8'hBA;
  localparam logic [11:0] ACK_TIMEOUT_RESET = 12'd2500;
  localparam logic [7:0]  TICKS_US_RESET    = 8'd1;

  // Delay lengths as a left shift of the microsecond tick count.
  localparam logic [1:0] DLY_1US = 2'd0;
  localparam logic [1:0] DLY_2US = 2'd1;
  localparam logic [1:0] DLY_4US = 2'd2;

  typedef enum logic [1:0] {
    K_TICK = 2'd0,
    K_IRQ  = 2'd1,
    K_READ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  sda;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_START_A  = 16'h0002,
    PH_START_B  = 16'h0004,
    PH_BIT_SET  = 16'h0008,
    PH_BIT_HI   = 16'h0010,
    PH_BIT_LO   = 16'h0020,
    PH_ACK_REL  = 16'h0040,
    PH_ACK_HI   = 16'h0080,
    PH_ACK_POLL = 16'h0100,
    PH_RD_LO    = 16'h0200,
    PH_RD_HI    = 16'h0400,
    PH_NACK_A   = 16'h0800,
    PH_NACK_B   = 16'h1000,
    PH_STOP_A   = 16'h2000,
    PH_STOP_B   = 16'h4000,
    PH_STOP_C   = 16'h8000
  } phase_t;

  typedef struct packed {
    logic       scl_high;
    logic       sda_pull_low;
    logic [7:0] key_value;
    logic       busy_res;
    logic       ack_missing;
  } result_t;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [11:0] ack_timeout;
    logic [7:0]  ticks_us;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/i2c_master_key_reader_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_key_reader_core
// I2C master that reads one key byte per key interrupt, one tick per word.
// ----------------------------------------------------------------------------
// Throughput: one word per clock while the output is not stalled; each tick
// is one step of the bus sequencer.
// A word accepted is written into the two-entry front queue, and its result
// goes to the output register when the output can take it.
// Reset (rst, synchronous): queue emptied, output invalid, sequencer idle,
// stored key and error flag cleared, registers back to their reset values.
// ----------------------------------------------------------------------------
module i2c_master_key_reader_core
  import imkr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic        sda_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl_high,
  output logic             sda_pull_low,
  output logic [7:0]       key_value,
  output logic             busy_res,
  output logic             ack_missing,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t    cfg;
  head_t   head;
  logic    pop;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_addr    <= DEV_ADDR_RESET;
      cfg.ack_timeout <= ACK_TIMEOUT_RESET;
      cfg.ticks_us    <= TICKS_US_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEV_ADDR:    cfg.dev_addr    <= cfg_data[7:0];
        CFG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data;
        CFG_TICKS_US:    cfg.ticks_us    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  imkr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .sda_in   (sda_in),
    .head     (head),
    .pop      (pop)
  );

  imkr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign scl_high     = result.scl_high;
  assign sda_pull_low = result.sda_pull_low;
  assign key_value    = result.key_value;
  assign busy_res     = result.busy_res;
  assign ack_missing  = result.ack_missing;

  // With no transaction running, both bus lines are released.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> scl_high && !sda_pull_low)
    else $error("bus lines not released while idle");

  // A queued word moves to the output whenever the output can take it.
  assert property (@(posedge clk) disable iff (rst)
    head.valid && !(out_valid && out_stall) |=> out_valid)
    else $error("sequencer did not take a queued word");

  // The front queue stalls only when full; this checks it never stalls while empty.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> head.valid)
    else $error("input stalled with an empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/imkr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imkr_front
// Accepts input words, sorts the request code into a kind and holds the
// words in a short queue until the sequencer takes them.
// ----------------------------------------------------------------------------
module imkr_front
  import imkr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] req_type,
  input  wire logic       sda_in,
  output head_t           head,
  input  wire logic       pop
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  kind_t               kind;

  always_comb begin
    case (req_type)
      REQ_KEY_IRQ: kind = K_IRQ;
      REQ_HOST_RD: kind = K_READ;
      default:     kind = K_TICK;
    endcase
  end

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind, sda: sda_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/imkr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imkr_back
// Bus sequencer: one queued word is one tick. Each tick serves a host read
// if it carries one, may start a transaction, drives the lines of the current
// phase and steps the phase timer. The result goes to an output register.
// ----------------------------------------------------------------------------
module imkr_back
  import imkr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire head_t head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [11:0] wait_count, wait_count_next;
  logic [11:0] poll_count, poll_count_next;
  logic [7:0]  stored_key, stored_key_next;
  logic        error_flag, error_flag_next;
  result_t     result_next;

  phase_t      ph;
  logic [11:0] wc;
  logic [11:0] wc_inc;
  logic [3:0]  bc_inc;
  logic [7:0]  tpu;
  logic [1:0]  dly;
  logic [9:0]  dur;
  logic        tdone;
  logic        timed;
  phase_t      target;
  logic        databit;

  assign pop = head.valid && !(out_valid && out_stall);

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    wait_count_next = wait_count;
    poll_count_next = poll_count;
    stored_key_next = stored_key;
    error_flag_next = error_flag;
    result_next     = '0;

    if (head.entry.kind == K_READ) begin
      result_next.key_value = stored_key;
      stored_key_next       = 8'd0;
    end

    ph = phase;
    wc = wait_count;
    if (head.entry.kind == K_IRQ && phase == PH_IDLE) begin
      shift_byte_next = cfg.dev_addr;
      bit_count_next  = 4'd0;
      poll_count_next = 12'd0;
      ph              = PH_START_A;
      wc              = 12'd0;
    end
    databit = shift_byte_next[7];

    result_next.scl_high     = 1'b1;
    result_next.sda_pull_low = 1'b0;
    case (ph)
      PH_START_B: result_next.sda_pull_low = 1'b1;
      PH_BIT_SET: begin
        result_next.scl_high     = 1'b0;
        result_next.sda_pull_low = !databit;
      end
      PH_BIT_HI:  result_next.sda_pull_low = !databit;
      PH_BIT_LO: begin
        result_next.scl_high     = 1'b0;
        result_next.sda_pull_low = !databit;
      end
      PH_ACK_REL, PH_RD_LO, PH_NACK_A: result_next.scl_high = 1'b0;
      PH_STOP_A: begin
        result_next.scl_high     = 1'b0;
        result_next.sda_pull_low = 1'b1;
      end
      PH_STOP_B:  result_next.sda_pull_low = 1'b1;
      default: begin
        result_next.scl_high     = 1'b1;
        result_next.sda_pull_low = 1'b0;
      end
    endcase
    result_next.busy_res    = (ph != PH_IDLE);
    result_next.ack_missing = error_flag;

    // Delay length and successor of each timed phase.
    timed  = 1'b1;
    target = PH_IDLE;
    dly    = DLY_1US;
    case (ph)
      PH_START_A: begin dly = DLY_4US; target = PH_START_B; end
      PH_START_B: begin dly = DLY_4US; target = PH_BIT_SET; end
      PH_BIT_SET: begin dly = DLY_2US; target = PH_BIT_HI;  end
      PH_BIT_HI:  begin dly = DLY_2US; target = PH_BIT_LO;  end
      PH_BIT_LO:  begin dly = DLY_2US; target = PH_BIT_SET; end
      PH_ACK_REL: begin dly = DLY_1US; target = PH_ACK_HI;  end
      PH_ACK_HI:  begin dly = DLY_1US; target = PH_ACK_POLL; end
      PH_RD_LO:   begin dly = DLY_2US; target = PH_RD_HI;   end
      PH_RD_HI:   begin dly = DLY_1US; target = PH_RD_LO;   end
      PH_NACK_A:  begin dly = DLY_2US; target = PH_NACK_B;  end
      PH_NACK_B:  begin dly = DLY_2US; target = PH_STOP_A;  end
      PH_STOP_A:  begin dly = DLY_4US; target = PH_STOP_B;  end
      PH_STOP_B:  begin dly = DLY_1US; target = PH_STOP_C;  end
      PH_STOP_C:  begin dly = DLY_4US; target = PH_IDLE;    end
      default:    timed = 1'b0;
    endcase

    tpu    = (cfg.ticks_us == 8'd0) ? 8'd1 : cfg.ticks_us;
    dur    = {2'b00, tpu} << dly;
    tdone  = ({1'b0, wc} + 13'd1) >= {3'b000, dur};
    wc_inc = wc + 12'd1;
    bc_inc = bit_count_next + 4'd1;

    phase_next      = ph;
    wait_count_next = wc;
    if (timed) begin
      if (tdone) begin
        phase_next      = target;
        wait_count_next = 12'd0;
      end else begin
        wait_count_next = wc_inc;
      end
    end

    case (ph)
      PH_BIT_LO: begin
        if (tdone) begin
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
          bit_count_next  = bc_inc;
          if (bc_inc[3]) begin
            phase_next = PH_ACK_REL;
          end
        end
      end
      PH_ACK_HI: begin
        if (tdone) begin
          poll_count_next = 12'd0;
        end
      end
      PH_ACK_POLL: begin
        if (!head.entry.sda) begin
          error_flag_next = 1'b0;
          shift_byte_next = 8'd0;
          bit_count_next  = 4'd0;
          phase_next      = PH_RD_LO;
          wait_count_next = 12'd0;
        end else if (poll_count_next >= cfg.ack_timeout) begin
          error_flag_next = 1'b1;
          phase_next      = PH_STOP_A;
          wait_count_next = 12'd0;
        end else begin
          poll_count_next = poll_count_next + 12'd1;
        end
      end
      PH_RD_HI: begin
        // SDA is sampled on the first tick of the SCL-high window.
        if (wc == 12'd0) begin
          shift_byte_next = {shift_byte_next[6:0], head.entry.sda};
        end
        if (tdone) begin
          bit_count_next = bc_inc;
          if (bc_inc[3]) begin
            phase_next = PH_NACK_A;
          end
        end
      end
      PH_NACK_B: begin
        if (tdone) begin
          stored_key_next = shift_byte_next;
        end
      end
      PH_IDLE: begin
        phase_next      = PH_IDLE;
        wait_count_next = 12'd0;
      end
      default: begin
        if (!timed) begin
          phase_next      = PH_IDLE;
          wait_count_next = 12'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_byte <= '0;
      wait_count <= '0;
      poll_count <= '0;
      stored_key <= '0;
      error_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        shift_byte <= shift_byte_next;
        wait_count <= wait_count_next;
        poll_count <= poll_count_next;
        stored_key <= stored_key_next;
        error_flag <= error_flag_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
